@@ src/lcg_pkg.sv @@
// Package for the label compaction core: payload word types and label constants.
// Depends on nothing; the core and its checker import it.
package lcg_pkg;

  localparam int LABEL_W     = 6;
  localparam int LABEL_SPACE = 64;
  localparam int TOTAL_W     = 7;

  typedef struct packed {
    logic [LABEL_W-1:0] node_label;
    logic               last_node;
  } item_t;

  typedef struct packed {
    logic [5:0]         node_index;
    logic [LABEL_W-1:0] new_community;
    logic               first_in_group;
    logic               end_of_run;
    logic [TOTAL_W-1:0] community_total;
    logic               label_error;
  } result_t;

endpackage

@@ src/label_compaction_group_by_label_core.sv @@
// Label compaction core: loads node labels, renumbers used labels densely and
// emits the nodes grouped by new community. Depends on lcg_pkg.
//
// Usage: an input word is taken at a clock edge where start is high and busy
// is low. Each word carries one node label in node order; last_node closes the
// set, and the MAX_NODES-th node closes it as well. Loading a word reads the tail
// pointer of the label's node list as the word is taken, then links the node in.
// After the closing word the block stays busy and walks the used-label bits
// upward, one label per cycle, and follows each used label's linked list through
// the next-pointer memory, one node per cycle. The length of a run is bounded by
// the label scan and the single read port of the pointer memory.
// Results appear on result for one cycle each, marked by done; the receiver
// cannot stall them. end_of_run marks the final word of a run, after which the
// block is idle again with the used-label bits cleared. Reset (rst, synchronous)
// returns the block to idle with an empty set; no memory clearing is needed.
module label_compaction_group_by_label_core #(
  parameter int MAX_NODES = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  lcg_pkg::item_t  item,
  output logic            done,
  output lcg_pkg::result_t result
);
  import lcg_pkg::*;

  localparam int IDXW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_FIND,
    S_EMIT
  } state_t;

  state_t state;

  // Per-label node lists: head and tail pointers, and a next pointer per node.
  logic [IDXW-1:0] head_mem [LABEL_SPACE];
  logic [IDXW-1:0] tail_mem [LABEL_SPACE];
  logic [IDXW-1:0] next_mem [MAX_NODES];
  logic [LABEL_SPACE-1:0] label_used;

  logic [IDXW-1:0]    head_q, tail_q, next_q;
  logic [LABEL_W-1:0] lab_q;
  logic               last_q;
  logic [IDXW-1:0]    count;
  logic [LABEL_W-1:0] max_label;
  logic [TOTAL_W-1:0] total;
  logic               error_seen;
  logic [LABEL_W-1:0] lbl;
  logic [LABEL_W-1:0] comm;
  logic [IDXW-1:0]    emitted;
  logic               first;

  logic [IDXW-1:0]    cur;
  logic [LABEL_W-1:0] tail_addr;
  logic [LABEL_W-1:0] max_next;
  logic               load_write;

  assign busy       = (state != S_IDLE);
  assign cur        = first ? head_q : next_q;
  assign tail_addr  = (state == S_IDLE) ? item.node_label : lbl;
  assign max_next   = (lab_q > max_label) ? lab_q : max_label;
  assign load_write = (state == S_LOAD);

  always_ff @(posedge clk) begin
    tail_q <= tail_mem[tail_addr];
    head_q <= head_mem[lbl];
    next_q <= next_mem[cur];
    if (load_write) begin
      tail_mem[lab_q] <= count;
      if (label_used[lab_q]) begin
        next_mem[tail_q] <= count;
      end else begin
        head_mem[lab_q] <= count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      label_used <= '0;
      count      <= '0;
      max_label  <= '0;
      total      <= '0;
      error_seen <= 1'b0;
      lbl        <= '0;
      comm       <= '0;
      emitted    <= '0;
      first      <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= (state == S_EMIT);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            lab_q  <= item.node_label;
            last_q <= item.last_node;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          label_used[lab_q] <= 1'b1;
          if (!label_used[lab_q]) begin
            total <= total + TOTAL_W'(1);
          end
          max_label <= max_next;
          if (last_q || count == IDXW'(MAX_NODES - 1)) begin
            // The set holds count+1 nodes; a label above count is out of range.
            error_seen <= (max_next > LABEL_W'(count));
            lbl        <= '0;
            comm       <= '0;
            emitted    <= '0;
            state      <= S_FIND;
          end else begin
            count <= count + IDXW'(1);
            state <= S_IDLE;
          end
        end
        S_FIND: begin
          if (label_used[lbl]) begin
            first <= 1'b1;
            state <= S_EMIT;
          end else begin
            lbl <= lbl + LABEL_W'(1);
          end
        end
        S_EMIT: begin
          result.node_index      <= 6'(cur);
          result.new_community   <= comm;
          result.first_in_group  <= first;
          result.end_of_run      <= (emitted == count);
          result.community_total <= total;
          result.label_error     <= error_seen;
          first                  <= 1'b0;
          emitted                <= emitted + IDXW'(1);
          if (emitted == count) begin
            label_used <= '0;
            count      <= '0;
            max_label  <= '0;
            total      <= '0;
            error_seen <= 1'b0;
            state      <= S_IDLE;
          end else if (cur == tail_q) begin
            lbl   <= lbl + LABEL_W'(1);
            comm  <= comm + LABEL_W'(1);
            state <= S_FIND;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/lcg_checker.sv @@
// Port-level checker for the label compaction core, with its bind statement.
// Depends on lcg_pkg and on label_compaction_group_by_label_core.
module lcg_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input lcg_pkg::result_t result
);
  import lcg_pkg::*;

  // An accepted word always keeps the block busy for the linking cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not make the core busy");

  // A run ends with the block ready for a new set.
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    done && result.end_of_run |-> !busy)
    else $error("core still busy on the final word of a run");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    done && !result.end_of_run |-> busy)
    else $error("core idle in the middle of a run");

  // Words of one community leave back to back with the same number.
  a_group_same: assert property (@(posedge clk) disable iff (rst)
    done && $past(done) && !result.first_in_group |->
      result.new_community == $past(result.new_community))
    else $error("community changed without a first-in-group mark");

  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> result.community_total != '0)
    else $error("result word with zero community total");

endmodule

bind label_compaction_group_by_label_core lcg_checker u_lcg_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

@@ tb/sv/label_compaction_group_by_label_core_tb.sv @@
// Testbench for label_compaction_group_by_label_core: drives label sets and checks every
// grouped result word against an in-bench model of the renumbering.
// Depends on lcg_pkg and the core RTL.
`timescale 1ns / 100ps

module label_compaction_group_by_label_core_tb;
  import lcg_pkg::*;

  localparam int NODE_LIMIT  = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN       = 200;

  // Keeps the label set being loaded and the grouped words it will produce.
  class community_ledger;
    result_t    grouped_q[$];
    logic [5:0] loaded_labels[$];
    bit         label_seen[LABEL_SPACE];
    int         fails = 0;
    int         reported = 0;
    int         checked = 0;
    int         error_runs = 0;

    function void load_label(item_t w);
      int         n;
      int         total;
      int         emitted;
      bit         err;
      bit         first;
      logic [5:0] new_id[LABEL_SPACE];
      result_t    r;
      loaded_labels = {loaded_labels, w.node_label};
      label_seen[w.node_label] = 1'b1;
      if (!w.last_node && loaded_labels.size() < NODE_LIMIT) return;
      n = loaded_labels.size();
      err = 1'b0;
      foreach (loaded_labels[i]) if (loaded_labels[i] >= n) err = 1'b1;
      // Out-of-range labels still get a dense number of their own.
      total = 0;
      for (int l = 0; l < LABEL_SPACE; l++) begin
        if (label_seen[l]) begin
          new_id[l] = total[5:0];
          total++;
        end
      end
      emitted = 0;
      for (int c = 0; c < total; c++) begin
        first = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (new_id[loaded_labels[i]] == c) begin
            r.node_index      = i[5:0];
            r.new_community   = c[5:0];
            r.first_in_group  = first;
            r.end_of_run      = (emitted == n - 1);
            r.community_total = total[6:0];
            r.label_error     = err;
            grouped_q = {grouped_q, r};
            first = 1'b0;
            emitted++;
          end
        end
      end
      if (err) error_runs++;
      foreach (label_seen[l]) label_seen[l] = 1'b0;
      loaded_labels.delete();
    endfunction

    function void check_word(result_t got);
      result_t exp;
      bit      bad;
      if (grouped_q.size() == 0) begin
        fails++;
        if (reported < 10) begin
          reported++;
          $display("Unexpected result word: node %0d comm %0d first %0b end %0b total %0d err %0b",
                   got.node_index, got.new_community, got.first_in_group, got.end_of_run,
                   got.community_total, got.label_error);
        end
        return;
      end
      exp = grouped_q.pop_front();
      checked++;
      bad = (got.node_index !== exp.node_index) ||
            (got.new_community !== exp.new_community) ||
            (got.first_in_group !== exp.first_in_group) ||
            (got.end_of_run !== exp.end_of_run) ||
            (got.community_total !== exp.community_total) ||
            (got.label_error !== exp.label_error);
      if (bad) begin
        fails++;
        if (reported < 10) begin
          reported++;
          $display("Result word %0d differs:", checked);
          $display("  expected node %0d comm %0d first %0b end %0b total %0d err %0b",
                   exp.node_index, exp.new_community, exp.first_in_group, exp.end_of_run,
                   exp.community_total, exp.label_error);
          $display("  got      node %0d comm %0d first %0b end %0b total %0d err %0b",
                   got.node_index, got.new_community, got.first_in_group, got.end_of_run,
                   got.community_total, got.label_error);
        end
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  logic    done;
  result_t result;

  community_ledger ledger = new;
  logic [5:0]      set_labels[$];
  int              gap_pct = 0;
  int              words_sent = 0;
  int              sets_sent = 0;
  int              full_sets = 0;
  int              cycle_count = 0;

  label_compaction_group_by_label_core #(
    .MAX_NODES(NODE_LIMIT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done === 1'b1) ledger.check_word(result);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles.", cycle_count);
    $display("label_compaction_group_by_label_core: mismatch");
    $finish;
  end

  // Start stays high from one word to the next unless a gap is drawn.
  task automatic send_word(input logic [5:0] lab, input bit last);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= '{node_label: lab, last_node: last};
    do @(posedge clk); while (busy !== 1'b0);
    ledger.load_label(item);
    words_sent++;
  endtask

  task automatic send_set(input bit close_last);
    foreach (set_labels[i])
      send_word(set_labels[i], (i == set_labels.size() - 1) ? close_last : 1'b0);
    sets_sent++;
    if (set_labels.size() == NODE_LIMIT) full_sets++;
  endtask

  // Mostly sets with every label below the node count; some with a stray label,
  // some with labels drawn from the whole range. Two sets fill the store.
  task automatic build_random_set(input int set_no);
    int n;
    int mode;
    int bad_pos;
    set_labels.delete();
    if (set_no == 6 || set_no == 30) n = NODE_LIMIT;
    else if ($urandom_range(7) == 0) n = $urandom_range(13, 40);
    else n = $urandom_range(1, 12);
    mode = $urandom_range(9);
    for (int i = 0; i < n; i++) begin
      if (mode == 9) set_labels = {set_labels, 6'($urandom_range(63))};
      else set_labels = {set_labels, 6'($urandom_range(n - 1))};
    end
    if ((mode == 7 || mode == 8) && n < NODE_LIMIT) begin
      bad_pos = $urandom_range(n - 1);
      set_labels[bad_pos] = 6'($urandom_range(n, 63));
    end
  endtask

  initial begin
    int phase_words;
    int set_no;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sets: single nodes in and out of range, swapped labels, one shared
    // label out of range, interleaved groups, the top label, and all singletons.
    set_labels = '{6'd0};                          send_set(1'b1);
    set_labels = '{6'd63};                         send_set(1'b1);
    set_labels = '{6'd1, 6'd0};                    send_set(1'b1);
    set_labels = '{6'd5, 6'd5, 6'd5};              send_set(1'b1);
    set_labels = '{6'd2, 6'd0, 6'd2, 6'd1};        send_set(1'b1);
    set_labels = '{6'd0, 6'd63, 6'd0, 6'd3, 6'd40}; send_set(1'b1);
    set_labels = '{6'd5, 6'd4, 6'd3, 6'd2, 6'd1, 6'd0};
    send_set(1'b1);

    set_no = 0;
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 30 : (phase == 1) ? 59 : 0;
      phase_words = 0;
      while (phase_words < 80) begin
        build_random_set(set_no);
        phase_words += set_labels.size();
        // A full store closes the set whatever the final flag says.
        send_set((set_labels.size() == NODE_LIMIT) ? 1'($urandom_range(1)) : 1'b1);
        set_no++;
      end
    end
    start <= 1'b0;

    while (ledger.grouped_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (ledger.grouped_q.size() != 0) begin
      $display("%0d expected result words never arrived.", ledger.grouped_q.size());
      ledger.fails += ledger.grouped_q.size();
    end
    $display("Loaded %0d label words in %0d sets (%0d filled the store, %0d had stray labels).",
             words_sent, sets_sent, full_sets, ledger.error_runs);
    $display("Checked %0d grouped result words; %0d failures.", ledger.checked, ledger.fails);
    if (ledger.fails == 0) begin
      $display("label_compaction_group_by_label_core: match");
    end else begin
      $display("label_compaction_group_by_label_core: mismatch");
    end
    $finish;
  end

endmodule

@@ label_compaction_group_by_label_core.f @@
src/lcg_pkg.sv
src/label_compaction_group_by_label_core.sv
src/lcg_checker.sv
tb/sv/label_compaction_group_by_label_core_tb.sv
